// File: rtl/slt_pkg.sv
// Shared types and constants for the segment linearity test block.
// Holds the fixed arithmetic widths of the eigenvalue test and the multiplier request.
package slt_pkg;

  localparam int RATIO_W     = 10;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 10'd10;
  localparam int COUNT_OUT_W = 13;

  // The covariance terms are kept to 64 bits and the eigen test products to 128 bits.
  localparam int LIMB_W  = 32;
  localparam int WORD_W  = 64;
  localparam int WIDE_W  = 128;
  localparam int A_LIMBS = WIDE_W / LIMB_W;
  localparam int B_LIMBS = WORD_W / LIMB_W;
  localparam int A_IDX_W = $clog2(A_LIMBS);
  localparam int B_IDX_W = $clog2(B_LIMBS);
  localparam int SH_W    = $clog2(A_LIMBS + B_LIMBS);

  localparam int QUEUE_DEPTH = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic               start;
    logic [A_IDX_W-1:0] a_last;
    logic [B_IDX_W-1:0] b_last;
  } mul_req_t;

endpackage

// File: rtl/segment_linearity_test_top.sv
// Segment linearity test. Points of one contour segment stream in one per cycle, the
// last one marked; on the marked point the block emits one result telling whether the
// larger covariance eigenvalue exceeds line_ratio times the smaller, exactly in integers.
// The front accumulates each accepted point; a finished segment goes into a two-entry
// queue, and the back runs twelve products in sequence on the shared 32x32 limb multiplier.
// Points stream at one per cycle; the input stalls only while the queue is full.
// cfg_ready_o is always high; write line_ratio only while no segment is in
// flight, since the back reads it during the test.
// Depends on slt_pkg, slt_front, slt_queue, slt_back.
module segment_linearity_test_top import slt_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int MAX_POINTS = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [RATIO_W-1:0]     line_ratio_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COORD_BITS-1:0]  point_x_i,
  input  logic [COORD_BITS-1:0]  point_y_i,
  input  logic                   last_point_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   keep_segment_o,
  output logic [COUNT_OUT_W-1:0] point_count_o,
  output logic                   too_long_o
);

  localparam int LOG_MAX = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int SUM_W   = LOG_MAX + COORD_BITS;
  localparam int SQ_W    = LOG_MAX + 2 * COORD_BITS;
  localparam int REC_W   = CNT_W + 2 * SUM_W + 3 * SQ_W + 1;

  logic             push, pop, q_full, q_empty;
  logic [REC_W-1:0] rec_in, rec_out;

  logic [CNT_W-1:0] f_n, b_n;
  logic [SUM_W-1:0] f_sx, f_sy, b_sx, b_sy;
  logic [SQ_W-1:0]  f_sxx, f_syy, f_sxy, b_sxx, b_syy, b_sxy;
  logic             f_ovf, b_ovf;

  assign cfg_ready_o = 1'b1;

  slt_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_point_i (last_point_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .rec_n_o      (f_n),
    .rec_sx_o     (f_sx),
    .rec_sy_o     (f_sy),
    .rec_sxx_o    (f_sxx),
    .rec_syy_o    (f_syy),
    .rec_sxy_o    (f_sxy),
    .rec_ovf_o    (f_ovf)
  );

  assign rec_in = {f_ovf, f_n, f_sx, f_sy, f_sxx, f_syy, f_sxy};
  assign {b_ovf, b_n, b_sx, b_sy, b_sxx, b_syy, b_sxy} = rec_out;

  slt_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (rec_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (rec_out)
  );

  slt_back #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .line_ratio_i   (line_ratio_i),
    .q_empty_i      (q_empty),
    .q_pop_o        (pop),
    .rec_n_i        (b_n),
    .rec_sx_i       (b_sx),
    .rec_sy_i       (b_sy),
    .rec_sxx_i      (b_sxx),
    .rec_syy_i      (b_syy),
    .rec_sxy_i      (b_sxy),
    .rec_ovf_i      (b_ovf),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .keep_segment_o (keep_segment_o),
    .point_count_o  (point_count_o),
    .too_long_o     (too_long_o)
  );

endmodule

// File: rtl/slt_front.sv
// Front part: accepts points, accumulates count and first and second moments.
// Pushes one record per finished segment into the queue. Depends on slt_pkg.
module slt_front import slt_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int MAX_POINTS = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [COORD_BITS-1:0]              point_x_i,
  input  logic [COORD_BITS-1:0]              point_y_i,
  input  logic                               last_point_i,
  input  logic                               q_full_i,
  output logic                               push_o,
  output logic [$clog2(MAX_POINTS+1)-1:0]    rec_n_o,
  output logic [$clog2(MAX_POINTS)+COORD_BITS-1:0]   rec_sx_o,
  output logic [$clog2(MAX_POINTS)+COORD_BITS-1:0]   rec_sy_o,
  output logic [$clog2(MAX_POINTS)+2*COORD_BITS-1:0] rec_sxx_o,
  output logic [$clog2(MAX_POINTS)+2*COORD_BITS-1:0] rec_syy_o,
  output logic [$clog2(MAX_POINTS)+2*COORD_BITS-1:0] rec_sxy_o,
  output logic                               rec_ovf_o
);

  localparam int LOG_MAX = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int SUM_W   = LOG_MAX + COORD_BITS;
  localparam int SQ_W    = LOG_MAX + 2 * COORD_BITS;

  logic [CNT_W-1:0]        count_q, count_d;
  logic [SUM_W-1:0]        sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [SQ_W-1:0]         sum_xx_q, sum_xx_d, sum_yy_q, sum_yy_d, sum_xy_q, sum_xy_d;
  logic                    ovf_q, ovf_d;
  logic [2*COORD_BITS-1:0] xx, yy, xy;
  logic                    accept;
  logic                    room;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign room       = count_q != CNT_W'(MAX_POINTS);

  assign xx = point_x_i * point_x_i;
  assign yy = point_y_i * point_y_i;
  assign xy = point_x_i * point_y_i;

  // Running sums including the point at the port; at capacity the point only sets the flag.
  always_comb begin
    count_d  = count_q;
    sum_x_d  = sum_x_q;
    sum_y_d  = sum_y_q;
    sum_xx_d = sum_xx_q;
    sum_yy_d = sum_yy_q;
    sum_xy_d = sum_xy_q;
    ovf_d    = ovf_q;
    if (room) begin
      count_d  = count_q + 1'b1;
      sum_x_d  = sum_x_q + SUM_W'(point_x_i);
      sum_y_d  = sum_y_q + SUM_W'(point_y_i);
      sum_xx_d = sum_xx_q + SQ_W'(xx);
      sum_yy_d = sum_yy_q + SQ_W'(yy);
      sum_xy_d = sum_xy_q + SQ_W'(xy);
    end else begin
      ovf_d = 1'b1;
    end
  end

  assign push_o    = accept & last_point_i;
  assign rec_n_o   = count_d;
  assign rec_sx_o  = sum_x_d;
  assign rec_sy_o  = sum_y_d;
  assign rec_sxx_o = sum_xx_d;
  assign rec_syy_o = sum_yy_d;
  assign rec_sxy_o = sum_xy_d;
  assign rec_ovf_o = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_yy_q <= '0;
      sum_xy_q <= '0;
      ovf_q    <= 1'b0;
    end else if (accept) begin
      if (last_point_i) begin
        count_q  <= '0;
        sum_x_q  <= '0;
        sum_y_q  <= '0;
        sum_xx_q <= '0;
        sum_yy_q <= '0;
        sum_xy_q <= '0;
        ovf_q    <= 1'b0;
      end else begin
        count_q  <= count_d;
        sum_x_q  <= sum_x_d;
        sum_y_q  <= sum_y_d;
        sum_xx_q <= sum_xx_d;
        sum_yy_q <= sum_yy_d;
        sum_xy_q <= sum_xy_d;
        ovf_q    <= ovf_d;
      end
    end
  end

endmodule

// File: rtl/slt_queue.sv
// Short queue of finished segment records between the front and back parts.
// Generic width and depth; only the default depth comes from slt_pkg.
module slt_queue import slt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/slt_mul.sv
// Limb-serial multiplier: one 32x32 partial product per cycle, added into a 128-bit sum.
// The product is taken modulo 2^128. Depends on slt_pkg.
module slt_mul import slt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  input  wide_t    a_i,
  input  word_t    b_i,
  output logic     done_o,
  output wide_t    prod_o
);

  wide_t                a_q;
  word_t                b_q;
  logic [A_IDX_W-1:0]   ai_q, a_last_q;
  logic [B_IDX_W-1:0]   bj_q, b_last_q;
  logic                 busy_q;
  logic [2*LIMB_W-1:0]  pp_q;
  logic [SH_W-1:0]      pp_sh_q;
  logic                 pp_vld_q, pp_last_q;
  wide_t                acc_q;
  logic                 done_q;
  logic [LIMB_W-1:0]    limb_a, limb_b;
  logic                 last_now;
  wide_t                pp_shifted;

  assign limb_a   = a_q[ai_q*LIMB_W +: LIMB_W];
  assign limb_b   = b_q[bj_q*LIMB_W +: LIMB_W];
  assign last_now = (ai_q == a_last_q) && (bj_q == b_last_q);

  // Shifts past the top of the sum fall away, which gives the modulo.
  assign pp_shifted = {{(WIDE_W - 2*LIMB_W){1'b0}}, pp_q} << (pp_sh_q * LIMB_W);

  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q      <= a_i;
      b_q      <= b_i;
      a_last_q <= req_i.a_last;
      b_last_q <= req_i.b_last;
    end
    if (busy_q) begin
      pp_q      <= limb_a * limb_b;
      pp_sh_q   <= SH_W'(ai_q) + SH_W'(bj_q);
      pp_last_q <= last_now;
    end
    if (req_i.start) begin
      acc_q <= '0;
    end else if (pp_vld_q) begin
      acc_q <= acc_q + pp_shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ai_q     <= '0;
      bj_q     <= '0;
      pp_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      pp_vld_q <= busy_q;
      done_q   <= pp_vld_q & pp_last_q;
      if (req_i.start) begin
        busy_q <= 1'b1;
        ai_q   <= '0;
        bj_q   <= '0;
      end else if (busy_q) begin
        if (last_now) begin
          busy_q <= 1'b0;
        end
        if (bj_q == b_last_q) begin
          bj_q <= '0;
          ai_q <= ai_q + 1'b1;
        end else begin
          bj_q <= bj_q + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/slt_back.sv
// Back part: takes one segment record at a time, forms the scaled covariance and runs
// the exact eigenvalue ratio test on the shared multiplier. Depends on slt_pkg, slt_mul.
module slt_back import slt_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int MAX_POINTS = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [RATIO_W-1:0]                 line_ratio_i,
  input  logic                               q_empty_i,
  output logic                               q_pop_o,
  input  logic [$clog2(MAX_POINTS+1)-1:0]    rec_n_i,
  input  logic [$clog2(MAX_POINTS)+COORD_BITS-1:0]   rec_sx_i,
  input  logic [$clog2(MAX_POINTS)+COORD_BITS-1:0]   rec_sy_i,
  input  logic [$clog2(MAX_POINTS)+2*COORD_BITS-1:0] rec_sxx_i,
  input  logic [$clog2(MAX_POINTS)+2*COORD_BITS-1:0] rec_syy_i,
  input  logic [$clog2(MAX_POINTS)+2*COORD_BITS-1:0] rec_sxy_i,
  input  logic                               rec_ovf_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               keep_segment_o,
  output logic [COUNT_OUT_W-1:0]             point_count_o,
  output logic                               too_long_o
);

  localparam int LOG_MAX = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int SUM_W   = LOG_MAX + COORD_BITS;
  localparam int SQ_W    = LOG_MAX + 2 * COORD_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_MUL   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  localparam logic [3:0] STEP_NSXX = 4'd0;
  localparam logic [3:0] STEP_SXSX = 4'd1;
  localparam logic [3:0] STEP_NSYY = 4'd2;
  localparam logic [3:0] STEP_SYSY = 4'd3;
  localparam logic [3:0] STEP_NSXY = 4'd4;
  localparam logic [3:0] STEP_SXSY = 4'd5;
  localparam logic [3:0] STEP_AC   = 4'd6;
  localparam logic [3:0] STEP_BB   = 4'd7;
  localparam logic [3:0] STEP_TT   = 4'd8;
  localparam logic [3:0] STEP_LHS  = 4'd9;
  localparam logic [3:0] STEP_DR   = 4'd10;
  localparam logic [3:0] STEP_RHS  = 4'd11;

  localparam logic [A_IDX_W-1:0] A_ONE  = A_IDX_W'(0);
  localparam logic [A_IDX_W-1:0] A_TWO  = A_IDX_W'(1);
  localparam logic [A_IDX_W-1:0] A_FOUR = A_IDX_W'(A_LIMBS - 1);
  localparam logic [B_IDX_W-1:0] B_ONE  = B_IDX_W'(0);
  localparam logic [B_IDX_W-1:0] B_TWO  = B_IDX_W'(B_LIMBS - 1);

  logic [1:0]         state_q;
  logic [3:0]         step_q;
  logic [RATIO_W-1:0] ratio_q;

  logic [CNT_W-1:0]   n_q;
  logic [SUM_W-1:0]   sx_q, sy_q;
  logic [SQ_W-1:0]    sxx_q, syy_q, sxy_q;
  logic               ovf_q;

  word_t              p_q, a_q, c_q, bmag_q, t_q;
  wide_t              w_q, tt_q;
  logic               le_q;

  mul_req_t           mul_req;
  wide_t              mul_a, mul_prod;
  word_t              mul_b, prod_lo, ratio_w, ratio_p1;
  logic               mul_done;
  logic [WIDE_W:0]    det_diff;
  logic               keep;
  logic               out_valid_q;
  logic               out_free;

  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign prod_lo  = mul_prod[WORD_W-1:0];
  assign ratio_w  = WORD_W'(ratio_q);
  assign ratio_p1 = ratio_w + 1'b1;
  assign det_diff = {1'b0, w_q} - {1'b0, mul_prod};

  always_comb begin
    mul_req.start  = state_q == ST_ISSUE;
    mul_req.a_last = A_ONE;
    mul_req.b_last = B_ONE;
    mul_a          = '0;
    mul_b          = '0;
    unique case (step_q)
      STEP_NSXX: begin
        mul_a = WIDE_W'(n_q);   mul_b = WORD_W'(sxx_q); mul_req.b_last = B_TWO;
      end
      STEP_SXSX: begin
        mul_a = WIDE_W'(sx_q);  mul_b = WORD_W'(sx_q);
      end
      STEP_NSYY: begin
        mul_a = WIDE_W'(n_q);   mul_b = WORD_W'(syy_q); mul_req.b_last = B_TWO;
      end
      STEP_SYSY: begin
        mul_a = WIDE_W'(sy_q);  mul_b = WORD_W'(sy_q);
      end
      STEP_NSXY: begin
        mul_a = WIDE_W'(n_q);   mul_b = WORD_W'(sxy_q); mul_req.b_last = B_TWO;
      end
      STEP_SXSY: begin
        mul_a = WIDE_W'(sx_q);  mul_b = WORD_W'(sy_q);
      end
      STEP_AC: begin
        mul_a = WIDE_W'(a_q);   mul_b = c_q;
        mul_req.a_last = A_TWO; mul_req.b_last = B_TWO;
      end
      STEP_BB: begin
        mul_a = WIDE_W'(bmag_q); mul_b = bmag_q;
        mul_req.a_last = A_TWO;  mul_req.b_last = B_TWO;
      end
      STEP_TT: begin
        mul_a = WIDE_W'(t_q);   mul_b = t_q;
        mul_req.a_last = A_TWO; mul_req.b_last = B_TWO;
      end
      STEP_LHS: begin
        mul_a = tt_q; mul_b = ratio_w;  mul_req.a_last = A_FOUR;
      end
      STEP_DR, STEP_RHS: begin
        mul_a = w_q;  mul_b = ratio_p1; mul_req.a_last = A_FOUR;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  slt_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // The final product (the right-hand side) stays in the multiplier while the result waits.
  always_comb begin
    priority if (n_q < CNT_W'(2)) begin
      keep = 1'b0;
    end else if (t_q == '0) begin
      keep = 1'b0;
    end else if (le_q) begin
      keep = 1'b1;
    end else if (ratio_q == '0) begin
      keep = 1'b1;
    end else begin
      keep = tt_q > mul_prod;
    end
  end

  // Record capture and arithmetic results.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      n_q   <= rec_n_i;
      sx_q  <= rec_sx_i;
      sy_q  <= rec_sy_i;
      sxx_q <= rec_sxx_i;
      syy_q <= rec_syy_i;
      sxy_q <= rec_sxy_i;
      ovf_q <= rec_ovf_i;
    end
    if (state_q == ST_MUL && mul_done) begin
      unique case (step_q)
        STEP_NSXX, STEP_NSYY, STEP_NSXY: p_q <= prod_lo;
        STEP_SXSX: a_q <= p_q - prod_lo;
        STEP_SYSY: c_q <= p_q - prod_lo;
        STEP_SXSY: begin
          bmag_q <= (p_q >= prod_lo) ? p_q - prod_lo : prod_lo - p_q;
          t_q    <= a_q + c_q;
        end
        STEP_AC: w_q <= mul_prod;
        STEP_BB: begin
          // A non-positive determinant counts as collinear.
          le_q <= det_diff[WIDE_W] | (det_diff[WIDE_W-1:0] == '0);
          w_q  <= det_diff[WIDE_W-1:0];
        end
        STEP_TT, STEP_LHS: tt_q <= mul_prod;
        STEP_DR: w_q <= mul_prod;
        default: ;
      endcase
    end
    if (state_q == ST_OUT && out_free) begin
      keep_segment_o <= keep;
      point_count_o  <= COUNT_OUT_W'(n_q);
      too_long_o     <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_NSXX;
      ratio_q     <= RATIO_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        ratio_q <= line_ratio_i;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            step_q  <= STEP_NSXX;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: state_q <= ST_MUL;
        ST_MUL: begin
          if (mul_done) begin
            if (step_q == STEP_RHS) begin
              state_q <= ST_OUT;
            end else begin
              step_q  <= step_q + 1'b1;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/slt_chk.sv
// Port-level checker for the segment linearity test, bound to the top level.
// Tracks marked points against delivered results. Depends on slt_pkg.
module slt_chk import slt_pkg::*; #(
  parameter int MAX_POINTS = 4096
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   last_point_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic                   keep_segment_o,
  input logic [COUNT_OUT_W-1:0] point_count_o,
  input logic                   too_long_o
);

  logic [3:0] pend_q;
  logic       last_acc, out_acc;

  assign last_acc = in_valid_i & ~in_stall_o & last_point_i;
  assign out_acc  = out_valid_o & ~out_stall_i;

  // Segments whose marked point was taken but whose result is not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(last_acc) - 4'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(keep_segment_o) && $stable(point_count_o) && $stable(too_long_o))
    else $error("result request changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != '0)
    else $error("result delivered with no marked point outstanding");

  a_too_long_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_long_o |-> point_count_o == COUNT_OUT_W'(MAX_POINTS))
    else $error("overflowed segment does not report a full count");

endmodule

bind segment_linearity_test_top slt_chk #(.MAX_POINTS(MAX_POINTS)) u_chk (.*);

// File: tb/sv/segment_linearity_test_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for segment_linearity_test_top: streams contour segments through
// the point channel, predicts every line verdict in a scoreboard class and checks the results.
// Depends on slt_pkg and the segment_linearity_test_top RTL.
module segment_linearity_test_top_tb;
  import slt_pkg::*;

  localparam int COORD_BITS   = 12;
  localparam int MAX_POINTS   = 4096;
  localparam int COORD_TOP    = (1 << COORD_BITS) - 1;
  localparam int DRAIN_CYCLES = 200;

  typedef enum int {
    SEG_SCATTER,
    SEG_LINE,
    SEG_NEAR_LINE,
    SEG_SAME,
    SEG_EXTREME
  } seg_shape_e;

  typedef struct packed {
    logic                   keep;
    logic [COUNT_OUT_W-1:0] count;
    logic                   too_long;
  } seg_verdict_t;

  // Keeps its own copy of the segment sums and of line_ratio, and the verdicts still owed.
  class segment_verdict_board;
    logic [RATIO_W-1:0] ratio;
    logic [12:0]        pts;
    logic [23:0]        sum_x, sum_y;
    logic [35:0]        sum_xx, sum_yy, sum_xy;
    logic               dropped;
    seg_verdict_t       verdicts_due[$];
    int                 errors;

    function new();
      ratio  = RATIO_RESET;
      errors = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      pts     = '0;
      sum_x   = '0;
      sum_y   = '0;
      sum_xx  = '0;
      sum_yy  = '0;
      sum_xy  = '0;
      dropped = 1'b0;
    endfunction

    // Exact test of lambda_max > ratio * lambda_min on the covariance scaled by n*n.
    function logic is_line();
      logic [63:0]  n, a, c, bp, bn, bmag, tr;
      logic [127:0] ac, bb, det, lhs, rhs, r1;
      n = 64'(pts);
      if (n < 2) return 1'b0;
      a  = n * 64'(sum_xx) - 64'(sum_x) * 64'(sum_x);
      c  = n * 64'(sum_yy) - 64'(sum_y) * 64'(sum_y);
      bp = n * 64'(sum_xy);
      bn = 64'(sum_x) * 64'(sum_y);
      bmag = (bp >= bn) ? bp - bn : bn - bp;
      tr = a + c;
      if (tr == 0) return 1'b0;
      ac = 128'(a) * 128'(c);
      bb = 128'(bmag) * 128'(bmag);
      // A zero determinant means collinear points and an unbounded ratio.
      if (ac <= bb) return 1'b1;
      det = ac - bb;
      if (ratio == 0) return 1'b1;
      lhs = (128'(tr) * 128'(tr)) * 128'(ratio);
      r1  = 128'(ratio) + 128'd1;
      rhs = (det * r1) * r1;
      return lhs > rhs;
    endfunction

    function void note_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y, logic last);
      seg_verdict_t v;
      if (int'(pts) < MAX_POINTS) begin
        pts    = pts + 13'd1;
        sum_x  = sum_x + 24'(x);
        sum_y  = sum_y + 24'(y);
        sum_xx = sum_xx + 36'(x) * 36'(x);
        sum_yy = sum_yy + 36'(y) * 36'(y);
        sum_xy = sum_xy + 36'(x) * 36'(y);
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        v.keep     = is_line();
        v.count    = pts;
        v.too_long = dropped;
        verdicts_due.insert(verdicts_due.size(), v);
        clear_sums();
      end
    endfunction

    function void check_verdict(logic keep, logic [COUNT_OUT_W-1:0] count, logic too_long);
      seg_verdict_t exp_v;
      if (verdicts_due.size() == 0) begin
        $display("%0t: result with none pending: keep_segment %0d point_count %0d too_long %0d",
                 $time, keep, count, too_long);
        errors++;
        return;
      end
      exp_v = verdicts_due.pop_front();
      if (keep !== exp_v.keep) begin
        $display("%0t: keep_segment expected %0d, actual %0d", $time, exp_v.keep, keep);
        errors++;
      end
      if (count !== exp_v.count) begin
        $display("%0t: point_count expected %0d, actual %0d", $time, exp_v.count, count);
        errors++;
      end
      if (too_long !== exp_v.too_long) begin
        $display("%0t: too_long expected %0d, actual %0d", $time, exp_v.too_long, too_long);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [RATIO_W-1:0]     line_ratio_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [COORD_BITS-1:0]  point_x_i;
  logic [COORD_BITS-1:0]  point_y_i;
  logic                   last_point_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   keep_segment_o;
  logic [COUNT_OUT_W-1:0] point_count_o;
  logic                   too_long_o;

  segment_verdict_board board = new();
  logic calm = 1'b0;
  int   stall_left = 0;

  segment_linearity_test_top #(
    .COORD_BITS(COORD_BITS),
    .MAX_POINTS(MAX_POINTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .line_ratio_i  (line_ratio_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .last_point_i  (last_point_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .keep_segment_o(keep_segment_o),
    .point_count_o (point_count_o),
    .too_long_o    (too_long_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none while calm is set.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_BITS-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > COORD_TOP) return COORD_BITS'(COORD_TOP);
    return COORD_BITS'(v);
  endfunction

  always @(posedge clk_i) begin
    int g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_verdict(keep_segment_o, point_count_o, too_long_o);
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        stall_left = g - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_point(x, y, last);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] value);
    wait_drained();
    cfg_valid_i  <= 1'b1;
    line_ratio_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.ratio = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_segment(input seg_shape_e shape, input int len);
    int m, dx, dy, span_x, span_y, x0, y0, nz, xi, yi;
    logic [COORD_BITS-1:0] base_x, base_y, px, py;
    m  = (len > 1) ? 4000 / (len - 1) : 4000;
    dx = int'($urandom_range(0, 2 * m)) - m;
    dy = int'($urandom_range(0, 2 * m)) - m;
    span_x = (dx < 0 ? -dx : dx) * (len - 1);
    span_y = (dy < 0 ? -dy : dy) * (len - 1);
    x0 = int'($urandom_range(0, COORD_TOP - span_x)) + (dx < 0 ? span_x : 0);
    y0 = int'($urandom_range(0, COORD_TOP - span_y)) + (dy < 0 ? span_y : 0);
    nz = (shape == SEG_NEAR_LINE) ? int'($urandom_range(1, 6)) : 0;
    base_x = COORD_BITS'($urandom);
    base_y = COORD_BITS'($urandom);
    for (int k = 0; k < len; k++) begin
      case (shape)
        SEG_SCATTER: begin
          px = COORD_BITS'($urandom);
          py = COORD_BITS'($urandom);
        end
        SEG_LINE, SEG_NEAR_LINE: begin
          xi = x0 + k * dx;
          yi = y0 + k * dy;
          if (nz > 0) begin
            xi += int'($urandom_range(0, 2 * nz)) - nz;
            yi += int'($urandom_range(0, 2 * nz)) - nz;
          end
          px = clip(xi);
          py = clip(yi);
        end
        SEG_SAME: begin
          px = base_x;
          py = base_y;
        end
        default: begin
          px = $urandom_range(0, 1) ? COORD_BITS'(COORD_TOP) : '0;
          py = $urandom_range(0, 1) ? COORD_BITS'(COORD_TOP) : '0;
        end
      endcase
      push_point(px, py, k == len - 1);
    end
  endtask

  task automatic run_random(input int items);
    int sent, r, len;
    seg_shape_e shape;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 7) == 0) calm = ~calm;
      // Now and then hold the sender back until the back stage has emptied out.
      if ($urandom_range(0, 99) == 0) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 30)      shape = SEG_LINE;
      else if (r < 65) shape = SEG_NEAR_LINE;
      else if (r < 80) shape = SEG_SCATTER;
      else if (r < 90) shape = SEG_SAME;
      else             shape = SEG_EXTREME;
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 64);
      send_segment(shape, len);
      sent += len;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    line_ratio_i <= '0;
    in_valid_i   <= 1'b0;
    point_x_i    <= '0;
    point_y_i    <= '0;
    last_point_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single points, identical points, two and three collinear points, a square and a
    // thin cloud, all at the reset ratio.
    push_point('0, '0, 1'b1);
    push_point(12'd4095, 12'd4095, 1'b1);
    for (int k = 0; k < 3; k++) push_point(12'd4095, 12'd0, k == 2);
    push_point(12'd0, 12'd100, 1'b0);
    push_point(12'd4095, 12'd100, 1'b1);
    push_point(12'd0, 12'd0, 1'b0);
    push_point(12'd2048, 12'd2048, 1'b0);
    push_point(12'd4095, 12'd4095, 1'b1);
    push_point(12'd0, 12'd0, 1'b0);
    push_point(12'd4095, 12'd0, 1'b0);
    push_point(12'd0, 12'd4095, 1'b0);
    push_point(12'd4095, 12'd4095, 1'b1);
    push_point(12'd0, 12'd0, 1'b0);
    push_point(12'd1000, 12'd1001, 1'b0);
    push_point(12'd2000, 12'd2000, 1'b0);
    push_point(12'd3000, 12'd3001, 1'b1);

    write_ratio('0);
    run_random(150);
    write_ratio('1);
    run_random(150);
    write_ratio(10'd1);
    run_random(150);
    write_ratio(RATIO_W'($urandom_range(2, 1022)));
    run_random(150);
    write_ratio(RATIO_W'($urandom_range(2, 40)));
    run_random(200);
    write_ratio(RATIO_RESET);
    run_random(250);
    wait_drained();

    if (board.verdicts_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.verdicts_due.size());
      board.errors += board.verdicts_due.size();
    end
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
